/* hw/rtl/mm2le_pkg.sv */
// ----------------------------------------------------------------------------
// mm2le_pkg
// Shared types, constants and small lookup functions for the MM2 locomotive
// frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mm2le_pkg;

    // Address space and field widths
    localparam int ADDRESS_COUNT = 81;
    localparam int ADDR_W        = 7;
    localparam int STEP_W        = 5;
    localparam int FUNC_W        = 4;
    localparam int CODE_W        = 4;
    localparam int FRAME_W       = 18;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;
    localparam int M_TUSER_W     = 4;

    // Speed step limits per mode
    localparam logic [STEP_W-1:0] STEP_LIMIT_14 = 5'd14;
    localparam logic [STEP_W-1:0] STEP_LIMIT_28 = 5'd28;

    // Line encoding of one trit: bit 0 goes out first
    localparam logic [1:0] TRIT_L = 2'b00;
    localparam logic [1:0] TRIT_O = 2'b01;
    localparam logic [1:0] TRIT_U = 2'b10;
    localparam logic [1:0] TRIT_H = 2'b11;

    // Direction masks for trits 5..8, bit k belongs to trit 5+k
    localparam logic [CODE_W-1:0] MASK_FWD_HIGH = 4'b0010; // L H L L
    localparam logic [CODE_W-1:0] MASK_FWD_LOW  = 4'b1010; // L H L H
    localparam logic [CODE_W-1:0] MASK_REV_HIGH = 4'b0101; // H L H L
    localparam logic [CODE_W-1:0] MASK_REV_LOW  = 4'b1101; // H L H H
    localparam logic [CODE_W-1:0] CODE_MID      = 4'd7;

    // Corrective function patterns
    localparam logic [2:0] PAT_FIX_OFF = 3'b101;
    localparam logic [2:0] PAT_FIX_ON  = 3'b010;

    // One input command, last field in the lowest bits
    typedef struct packed {
        logic              func_four;
        logic              func_three;
        logic              func_two;
        logic              func_one;
        logic              light_on;
        logic [STEP_W-1:0] speed_step;
        logic              direction;
        logic [ADDR_W-1:0] loco_address;
    } loco_cmd_t;

    // One result item
    typedef struct packed {
        logic               rejected;
        logic [1:0]         function_number;
        logic               is_function_frame;
        logic [FRAME_W-1:0] frame_bits;
    } loco_result_t;

    // Write to the function bit store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [FUNC_W-1:0] data;
    } fn_wr_t;

    // Pattern on the second bits of trits 5..7 for function 1..4
    function automatic logic [2:0] fn_pattern(input logic [1:0] sel);
        logic [2:0] pat;
        case (sel)
            2'd0:    pat = 3'b011;
            2'd1:    pat = 3'b100;
            2'd2:    pat = 3'b110;
            default: pat = 3'b111;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mm2le_ram.sv */
// ----------------------------------------------------------------------------
// mm2le_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2le_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 81
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mm2le_fn_store.sv */
// ----------------------------------------------------------------------------
// mm2le_fn_store
// Last function bits of every address: RAM plus per-entry valid bits, with
// forwarding of a write that lands in the same cycle as the read.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2le_fn_store
    import mm2le_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic [ADDR_W-1:0] cur_addr,
    input  wire fn_wr_t            wr,
    output logic      [FUNC_W-1:0] old_bits
);

    logic [ADDRESS_COUNT-1:0] valid_reg;
    logic [ADDRESS_COUNT-1:0] valid_next;
    logic                     fwd_reg;
    logic                     fwd_next;
    logic [FUNC_W-1:0]        fwd_data_reg;
    logic [FUNC_W-1:0]        fwd_data_next;
    logic [FUNC_W-1:0]        ram_q;
    logic                     cur_in_range;

    mm2le_ram #(
        .WIDTH (FUNC_W),
        .DEPTH (ADDRESS_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Mark written entries, capture a same-cycle write for the new item
    always_comb begin
        valid_next    = valid_reg;
        fwd_next      = fwd_reg;
        fwd_data_next = fwd_data_reg;
        if (wr.en) begin
            valid_next[wr.addr] = 1'b1;
        end
        if (rd_en) begin
            fwd_next      = wr.en && (wr.addr == rd_addr);
            fwd_data_next = wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= fwd_data_next;
    end

    // Select forwarded, stored or reset value
    assign cur_in_range = (cur_addr < ADDR_W'(ADDRESS_COUNT));

    always_comb begin
        if (fwd_reg) begin
            old_bits = fwd_data_reg;
        end else if (cur_in_range && valid_reg[cur_addr]) begin
            old_bits = ram_q;
        end else begin
            old_bits = '0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mm2le_frame.sv */
// ----------------------------------------------------------------------------
// mm2le_frame
// Builds the 9-trit line frame for one command: address trits, light and
// half-step trit, masked speed trits and the function frame overlay.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2le_frame
    import mm2le_pkg::*;
(
    input  wire loco_cmd_t         cmd,
    input  wire logic              speed_mode,
    input  wire logic [FUNC_W-1:0] old_bits,
    output loco_result_t           result,
    output logic                   in_range,
    output logic      [FUNC_W-1:0] new_bits
);

    logic [ADDR_W-1:0]  a3;
    logic [ADDR_W-1:0]  a2;
    logic [ADDR_W-1:0]  a1;
    logic [1:0]         d3;
    logic [1:0]         d2;
    logic [1:0]         d1;
    logic [1:0]         d0;
    logic [STEP_W-1:0]  limit;
    logic [STEP_W:0]    step_inc;
    logic [CODE_W-1:0]  code;
    logic [1:0]         trit4;
    logic [CODE_W-1:0]  mask;
    logic [FUNC_W-1:0]  diff;
    logic               changed;
    logic [1:0]         sel;
    logic               fon;
    logic [2:0]         pat;
    logic [FRAME_W-1:0] frame;

    function automatic logic [1:0] digit_trit(input logic [1:0] d);
        logic [1:0] t;
        case (d)
            2'd0:    t = TRIT_L;
            2'd1:    t = TRIT_H;
            default: t = TRIT_O;
        endcase
        return t;
    endfunction

    assign new_bits = {cmd.func_four, cmd.func_three, cmd.func_two, cmd.func_one};

    // Range check
    assign limit    = speed_mode ? STEP_LIMIT_28 : STEP_LIMIT_14;
    assign in_range = (cmd.loco_address < ADDR_W'(ADDRESS_COUNT))
                      && (cmd.speed_step <= limit);

    // Split the address into base-3 digits by compare and subtract
    always_comb begin
        a3 = cmd.loco_address;
        if (a3 >= 7'd54) begin
            d3 = 2'd2;
            a2 = a3 - 7'd54;
        end else if (a3 >= 7'd27) begin
            d3 = 2'd1;
            a2 = a3 - 7'd27;
        end else begin
            d3 = 2'd0;
            a2 = a3;
        end
        if (a2 >= 7'd18) begin
            d2 = 2'd2;
            a1 = a2 - 7'd18;
        end else if (a2 >= 7'd9) begin
            d2 = 2'd1;
            a1 = a2 - 7'd9;
        end else begin
            d2 = 2'd0;
            a1 = a2;
        end
        if (a1 >= 7'd6) begin
            d1 = 2'd2;
            d0 = a1[1:0] - 2'd2;
        end else if (a1 >= 7'd3) begin
            d1 = 2'd1;
            d0 = a1[1:0] + 2'd1;
        end else begin
            d1 = 2'd0;
            d0 = a1[1:0];
        end
    end

    // Speed code and trit 4
    assign step_inc = {1'b0, cmd.speed_step} + 6'd1;

    always_comb begin
        if (cmd.speed_step == '0) begin
            code = '0;
        end else if (speed_mode) begin
            code = step_inc[CODE_W:1] + 4'd1;
        end else begin
            code = step_inc[CODE_W-1:0];
        end
        if (speed_mode && !cmd.speed_step[0]) begin
            trit4 = cmd.light_on ? TRIT_O : TRIT_U;
        end else begin
            trit4 = cmd.light_on ? TRIT_H : TRIT_L;
        end
        if (cmd.direction) begin
            mask = (code > CODE_MID) ? MASK_FWD_HIGH : MASK_FWD_LOW;
        end else begin
            mask = (code > CODE_MID) ? MASK_REV_HIGH : MASK_REV_LOW;
        end
    end

    // Lowest changed function wins
    assign diff    = old_bits ^ new_bits;
    assign changed = |diff;

    always_comb begin
        if (diff[0]) begin
            sel = 2'd0;
        end else if (diff[1]) begin
            sel = 2'd1;
        end else if (diff[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    // Function pattern with the corrective cases
    always_comb begin
        fon = new_bits[sel];
        pat = fn_pattern(sel);
        if (code == {1'b0, fn_pattern(sel)} && !fon) begin
            pat = PAT_FIX_OFF;
        end
        if (code == {1'b1, fn_pattern(sel)} && fon) begin
            pat = PAT_FIX_ON;
        end
    end

    // Assemble the frame; a speed trit is {mask bit, code bit}
    always_comb begin
        frame = {
            mask[3], code[3], mask[2], code[2], mask[1], code[1], mask[0], code[0],
            trit4, digit_trit(d3), digit_trit(d2), digit_trit(d1), digit_trit(d0)
        };
        if (changed) begin
            frame[11] = pat[0];
            frame[13] = pat[1];
            frame[15] = pat[2];
            frame[17] = fon;
        end
    end

    // Drop everything on a rejected command
    always_comb begin
        if (in_range) begin
            result.frame_bits        = frame;
            result.is_function_frame = changed;
            result.function_number   = changed ? sel : 2'd0;
            result.rejected          = 1'b0;
        end else begin
            result.frame_bits        = '0;
            result.is_function_frame = 1'b0;
            result.function_number   = 2'd0;
            result.rejected          = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mm2_loco_packet_encoder.sv */
// ----------------------------------------------------------------------------
// mm2_loco_packet_encoder
// MM2 locomotive frame encoder: one command beat in, one frame beat out.
//
//  Channel | Dir | Signals                          | Payload
//  --------+-----+----------------------------------+--------------------------
//  s_      | in  | s_tvalid s_tready s_tdata[23:0]  | locomotive command
//  m_      | out | m_tvalid m_tready m_tdata m_tuser| frame and frame kind
//  cfg_    | in  | cfg_we cfg_wdata                 | speed_mode
//
// An input beat passes the input stage, where the function bit RAM is read,
// and then the output register. Throughput is one beat per cycle while the
// output is not stalled. After reset all stored function bits read as zero
// at once (per-entry valid bits) and speed_mode is 0. A stalled output holds
// its beat; the input stage takes one more beat behind it and then drops
// s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module mm2_loco_packet_encoder
    import mm2le_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,   // speed_mode
    // Command stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [6:0] loco_address, [7] direction, [12:8] speed_step, [13] light_on,
    // [14] func_one, [15] func_two, [16] func_three, [17] func_four
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // Frame stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [17:0] frame_bits
    output logic      [M_TDATA_W-1:0] m_tdata,
    // [0] is_function_frame, [2:1] function_number, [3] rejected
    output logic      [M_TUSER_W-1:0] m_tuser
);

    logic               speed_mode_reg;
    logic               speed_mode_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    loco_cmd_t          s1_cmd_reg;
    loco_cmd_t          s1_cmd_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    loco_result_t       m_result_reg;
    loco_result_t       m_result_next;
    loco_cmd_t          in_cmd;
    logic               accept;
    logic               advance;
    logic [FUNC_W-1:0]  old_bits;
    loco_result_t       result;
    logic               in_range;
    logic [FUNC_W-1:0]  new_bits;
    fn_wr_t             fn_wr;

    assign in_cmd   = loco_cmd_t'(s_tdata[$bits(loco_cmd_t)-1:0]);
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Store the new function bits of an in-range command once it leaves the input stage
    always_comb begin
        fn_wr.en   = advance && in_range;
        fn_wr.addr = s1_cmd_reg.loco_address;
        fn_wr.data = new_bits;
    end

    mm2le_fn_store u_fn_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept && (in_cmd.loco_address < ADDR_W'(ADDRESS_COUNT))),
        .rd_addr  (in_cmd.loco_address),
        .cur_addr (s1_cmd_reg.loco_address),
        .wr       (fn_wr),
        .old_bits (old_bits)
    );

    mm2le_frame u_frame (
        .cmd        (s1_cmd_reg),
        .speed_mode (speed_mode_reg),
        .old_bits   (old_bits),
        .result     (result),
        .in_range   (in_range),
        .new_bits   (new_bits)
    );

    // Next values of the stages and the config register
    always_comb begin
        speed_mode_next = cfg_we ? cfg_wdata : speed_mode_reg;
        s1_valid_next   = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        s1_cmd_next     = accept ? in_cmd : s1_cmd_reg;
        m_valid_next    = advance ? 1'b1 : ((m_valid_reg && !m_tready) ? 1'b1 : 1'b0);
        m_result_next   = advance ? result : m_result_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_mode_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            speed_mode_reg <= speed_mode_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_cmd_reg   <= s1_cmd_next;
        m_result_reg <= m_result_next;
    end

    // Drive the output beat
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-FRAME_W){1'b0}}, m_result_reg.frame_bits};
    assign m_tuser  = {m_result_reg.rejected, m_result_reg.function_number,
                       m_result_reg.is_function_frame};

    // A rejected beat carries an empty frame and no function selection
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_result_reg.rejected |->
            m_result_reg.frame_bits == '0 && !m_result_reg.is_function_frame
            && m_result_reg.function_number == 2'd0)
        else $error("rejected beat carries payload");

    // Function number only on a function frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_result_reg.is_function_frame |->
            m_result_reg.function_number == 2'd0)
        else $error("function number set on speed frame");

    // Store writes stay inside the address space
    assert property (@(posedge aclk) disable iff (!aresetn)
        fn_wr.en |-> fn_wr.addr < ADDR_W'(ADDRESS_COUNT))
        else $error("function store write out of range");

    // A command leaving the input stage shows up on the output next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced beat lost");

    // The input stage never takes a beat while holding one it cannot pass on
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_tready |-> !s_tready)
        else $error("input stage overrun");

endmodule

`default_nettype wire

/* bench/tb_mm2_loco_packet_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mm2_loco_packet_encoder
// Self-checking bench for the MM2 locomotive frame encoder. Commands are sent
// as command beats; a local predictor keeps its own copy of the per-address
// function bits and the speed mode and builds the expected frame for every
// accepted command. Frame beats are checked field by field against the oldest
// prediction. Directed cases cover both speed modes, rejects and every
// function pattern; random traffic runs under several idle/stall mixes and
// one long output hold-off.
// ----------------------------------------------------------------------------

module tb_mm2_loco_packet_encoder;

    import mm2le_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 110;

    // Second-bit patterns of trits 5..7 and the codes that need a corrective
    // pattern, 3 or 4 bits per function, function 1 in the lowest bits
    localparam logic [11:0] FUNC_PATTERNS  = {3'd7, 3'd6, 3'd4, 3'd3};
    localparam logic [15:0] FIX_LOW_CODES  = {4'd7, 4'd6, 4'd4, 4'd3};
    localparam logic [15:0] FIX_HIGH_CODES = {4'd15, 4'd14, 4'd12, 4'd11};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Predictor state
    logic [FUNC_W-1:0] fn_history [ADDRESS_COUNT];
    logic              mode_28 = 1'b0;
    loco_result_t      expected_frames [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_cycles = 0;
    int quiet_cycles   = 0;

    mm2_loco_packet_encoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Build the expected frame of one accepted command and update history
    function automatic loco_result_t predict_frame(input loco_cmd_t c);
        loco_result_t      r;
        logic [FUNC_W-1:0] fb;
        logic [FUNC_W-1:0] prev;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] mask;
        logic [1:0]        t4;
        logic [2:0]        pat;
        logic [STEP_W-1:0] lim;
        logic              fon;
        int                rest;
        int                d;
        int                k;
        int                sel;
        r    = '0;
        fb   = {c.func_four, c.func_three, c.func_two, c.func_one};
        lim  = mode_28 ? STEP_LIMIT_28 : STEP_LIMIT_14;
        if (c.loco_address >= ADDRESS_COUNT || c.speed_step > lim) begin
            r.rejected = 1'b1;
            return r;
        end
        // speed code and light trit
        if (c.speed_step == 0)
            code = '0;
        else if (!mode_28)
            code = CODE_W'(int'(c.speed_step) + 1);
        else
            code = CODE_W'((int'(c.speed_step) + 1) / 2 + 1);
        if (mode_28 && !c.speed_step[0])
            t4 = c.light_on ? TRIT_O : TRIT_U;
        else
            t4 = c.light_on ? TRIT_H : TRIT_L;
        // address trits, base 3, least significant first
        rest = int'(c.loco_address);
        for (k = 0; k < 4; k++) begin
            d    = rest % 3;
            rest = rest / 3;
            r.frame_bits[2*k +: 2] = (d == 0) ? TRIT_L : ((d == 1) ? TRIT_H : TRIT_O);
        end
        r.frame_bits[9:8] = t4;
        // speed trits shaped by the direction mask
        if (c.direction)
            mask = (code > CODE_MID) ? MASK_FWD_HIGH : MASK_FWD_LOW;
        else
            mask = (code > CODE_MID) ? MASK_REV_HIGH : MASK_REV_LOW;
        for (k = 0; k < 4; k++) begin
            if (code[k])
                r.frame_bits[10 + 2*k +: 2] = mask[k] ? TRIT_H : TRIT_O;
            else
                r.frame_bits[10 + 2*k +: 2] = mask[k] ? TRIT_U : TRIT_L;
        end
        // lowest changed function wins
        prev = fn_history[c.loco_address];
        sel  = -1;
        for (k = FUNC_W - 1; k >= 0; k--) begin
            if (prev[k] != fb[k])
                sel = k;
        end
        fn_history[c.loco_address] = fb;
        if (sel >= 0) begin
            fon = fb[sel];
            pat = FUNC_PATTERNS[3*sel +: 3];
            if (code == FIX_LOW_CODES[4*sel +: 4] && !fon)
                pat = PAT_FIX_OFF;
            if (code == FIX_HIGH_CODES[4*sel +: 4] && fon)
                pat = PAT_FIX_ON;
            r.frame_bits[11]     = pat[0];
            r.frame_bits[13]     = pat[1];
            r.frame_bits[15]     = pat[2];
            r.frame_bits[17]     = fon;
            r.is_function_frame  = 1'b1;
            r.function_number    = sel[1:0];
        end
        return r;
    endfunction

    function automatic loco_cmd_t make_cmd(input int addr, input logic dir, input int step,
                                           input logic light, input logic [3:0] funcs);
        loco_cmd_t c;
        c.loco_address = addr[ADDR_W-1:0];
        c.direction    = dir;
        c.speed_step   = step[STEP_W-1:0];
        c.light_on     = light;
        {c.func_four, c.func_three, c.func_two, c.func_one} = funcs;
        return c;
    endfunction

    // Mostly well-formed commands on a few hot addresses, some noise
    function automatic loco_cmd_t random_command();
        loco_cmd_t         c;
        logic [FUNC_W-1:0] f;
        int                pick;
        int                k;
        pick        = $urandom_range(99);
        c.direction = 1'($urandom_range(1));
        c.light_on  = 1'($urandom_range(1));
        if (pick < 10) begin
            c.loco_address = ADDR_W'($urandom_range(127));
            c.speed_step   = STEP_W'($urandom_range(31));
            f              = FUNC_W'($urandom_range(15));
        end else begin
            if ($urandom_range(1))
                c.loco_address = ADDR_W'($urandom_range(7));
            else
                c.loco_address = ADDR_W'($urandom_range(ADDRESS_COUNT - 1));
            c.speed_step = STEP_W'($urandom_range(mode_28 ? 28 : 14));
            f = fn_history[c.loco_address];
            if (pick < 50) begin
                k    = $urandom_range(FUNC_W - 1);
                f[k] = ~f[k];
            end else if (pick < 65) begin
                f = FUNC_W'($urandom_range(15));
            end
        end
        {c.func_four, c.func_three, c.func_two, c.func_one} = f;
        return c;
    endfunction

    // Offer one command beat, idling first at the current rate; valid stays
    // high after acceptance so back-to-back beats need no extra edge
    task automatic send_command(input loco_cmd_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - $bits(loco_cmd_t)){1'b0}}, c};
        do @(posedge aclk); while (!s_tready);
        expected_frames.push_back(predict_frame(c));
    endtask

    // Stop sending and wait until every predicted frame has come out
    task automatic drain_frames();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_speed_mode(input logic mode);
        drain_frames();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_28    = mode;
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatch_count++;
    endtask

    // Extremes, rejects, every function on and off, corrective patterns
    task automatic test_directed_14_step();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_speed_mode(1'b0);
        send_command(make_cmd(0,   1'b1, 0,  1'b0, 4'b0000));
        send_command(make_cmd(80,  1'b0, 14, 1'b1, 4'b0000));
        send_command(make_cmd(81,  1'b1, 0,  1'b0, 4'b0000));
        send_command(make_cmd(127, 1'b0, 31, 1'b1, 4'b1111));
        // rejected command must leave the function bits alone
        send_command(make_cmd(7,   1'b1, 15, 1'b0, 4'b0001));
        send_command(make_cmd(7,   1'b1, 1,  1'b0, 4'b0000));
        // functions switched on at the high corrective codes
        send_command(make_cmd(10,  1'b1, 10, 1'b0, 4'b0001));
        send_command(make_cmd(10,  1'b0, 11, 1'b1, 4'b0011));
        send_command(make_cmd(10,  1'b1, 13, 1'b0, 4'b0111));
        send_command(make_cmd(10,  1'b0, 14, 1'b1, 4'b1111));
        // functions switched off at the low corrective codes
        send_command(make_cmd(10,  1'b1, 2,  1'b0, 4'b1110));
        send_command(make_cmd(10,  1'b0, 3,  1'b1, 4'b1100));
        send_command(make_cmd(10,  1'b1, 5,  1'b0, 4'b1000));
        send_command(make_cmd(10,  1'b0, 6,  1'b1, 4'b0000));
        // several changes at once, then no change
        send_command(make_cmd(20,  1'b1, 7,  1'b1, 4'b1111));
        send_command(make_cmd(20,  1'b0, 7,  1'b0, 4'b1111));
        send_command(make_cmd(40,  1'b0, 4,  1'b0, 4'b0100));
        send_command(make_cmd(64,  1'b1, 0,  1'b1, 4'b0000));
        drain_frames();
    endtask

    // Half-step trit and the wider step range
    task automatic test_directed_28_step();
        write_speed_mode(1'b1);
        send_command(make_cmd(0,  1'b1, 28, 1'b1, 4'b0000));
        send_command(make_cmd(0,  1'b1, 27, 1'b0, 4'b0000));
        send_command(make_cmd(1,  1'b0, 0,  1'b0, 4'b0000));
        send_command(make_cmd(2,  1'b0, 29, 1'b1, 4'b0000));
        send_command(make_cmd(3,  1'b1, 15, 1'b1, 4'b0000));
        send_command(make_cmd(4,  1'b1, 2,  1'b1, 4'b0010));
        send_command(make_cmd(80, 1'b0, 31, 1'b0, 4'b0000));
        send_command(make_cmd(5,  1'b1, 1,  1'b0, 4'b0000));
        drain_frames();
    endtask

    // Random commands in both modes under each idle/stall mix
    task automatic test_random_traffic();
        int phase;
        int m;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (m = 0; m < 2; m++) begin
                write_speed_mode(m[0]);
                repeat (RAND_ITEMS) send_command(random_command());
            end
        end
        drain_frames();
    endtask

    // Hold the output off long enough for the block to fill and stall input
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_speed_mode(1'b0);
        rx_hold_cycles = HOLD_CYCLES;
        repeat (40) send_command(random_command());
        drain_frames();
    endtask

    // Receiver: long hold-off when asked, otherwise random stalls
    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready       <= 1'b0;
            rx_hold_cycles  = rx_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each frame beat with the oldest prediction
    always @(posedge aclk) begin : check_frames
        loco_result_t got;
        loco_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[FRAME_W-1:0]};
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected frame beat, expected none, actual 0x%0h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                if (got.frame_bits !== want.frame_bits)
                    report_field("frame_bits", want.frame_bits, got.frame_bits);
                if (got.is_function_frame !== want.is_function_frame)
                    report_field("is_function_frame", want.is_function_frame,
                                 got.is_function_frame);
                if (got.function_number !== want.function_number)
                    report_field("function_number", want.function_number,
                                 got.function_number);
                if (got.rejected !== want.rejected)
                    report_field("rejected", want.rejected, got.rejected);
            end
        end
    end

    // Abort when no beat moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles = quiet_cycles + 1;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d frames outstanding",
                     $time, quiet_cycles, expected_frames.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int a = 0; a < ADDRESS_COUNT; a++)
            fn_history[a] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_14_step();
        test_directed_28_step();
        test_random_traffic();
        test_output_backpressure();

        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
